>>> rtl/izn_pkg.sv
package izn_pkg;

   // Field widths
   localparam int IDX_W     = 10;
   localparam int INC_W     = 31;
   localparam int Q_W       = 32;
   localparam int CFG_W     = 25;
   localparam int CSR_IDX_W = 4;

   // Register indexes on the CSR port
   localparam logic [CSR_IDX_W-1:0] CSR_DT_SCALE       = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADAPT_STEP     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ADAPT_GAIN     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_VOLTAGE  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIKE_ADAPT    = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD      = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPA_DECAY     = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_GABA_DECAY     = 4'd7;

   // Q8.24 limits and model constants
   localparam logic signed [Q_W-1:0] Q_MAX      = 32'sh7FFF_FFFF;
   localparam logic signed [Q_W-1:0] Q_MIN      = 32'sh8000_0000;
   localparam logic signed [Q_W-1:0] K_FORTY    = 32'sd671088640;
   localparam logic signed [Q_W-1:0] K_FIVE     = 32'sd83886080;
   localparam logic signed [Q_W-1:0] K_OFFSET   = 32'sd2348810;
   localparam logic signed [Q_W-1:0] K_EREV_INH = -32'sd1342177;
   localparam logic signed [Q_W-1:0] RST_MEMBRANE = -32'sd1090519;

   typedef struct packed {
      logic [IDX_W-1:0] neuron_index;
      logic [INC_W-1:0] ampa_increment;
      logic [INC_W-1:0] gaba_increment;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]        neuron_out;
      logic                    spiked;
      logic signed [Q_W-1:0]   membrane;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0]        dt_scale;
      logic [CFG_W-1:0]        adapt_step;
      logic [CFG_W-1:0]        adapt_gain;
      logic signed [Q_W-1:0]   reset_voltage;
      logic signed [Q_W-1:0]   spike_adapt_add;
      logic signed [Q_W-1:0]   threshold;
      logic [CFG_W-1:0]        ampa_decay;
      logic [CFG_W-1:0]        gaba_decay;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      dt_scale:        25'd1677722,
      adapt_step:      25'd33554,
      adapt_gain:      25'd3355443,
      reset_voltage:   RST_MEMBRANE,
      spike_adapt_add: 32'sd33554,
      threshold:       32'sd503316,
      ampa_decay:      25'd16445021,
      gaba_decay:      25'd16610265
   };

   // One entry of the neuron state RAM
   typedef struct packed {
      logic signed [Q_W-1:0] membrane;
      logic signed [Q_W-1:0] adaptation;
      logic signed [Q_W-1:0] excit;
      logic signed [Q_W-1:0] inhib;
   } nrn_type;

   localparam nrn_type NRN_RESET = '{
      membrane:   RST_MEMBRANE,
      adaptation: '0,
      excit:      '0,
      inhib:      '0
   };

   // Write-back from the update pipeline
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      nrn_type          data;
   } wb_type;

   // Clamp a 33-bit sum to the Q8.24 range
   function automatic logic signed [Q_W-1:0] sat33(input logic signed [Q_W:0] s);
      if (s[Q_W] != s[Q_W-1]) begin
         return s[Q_W] ? Q_MIN : Q_MAX;
      end
      return s[Q_W-1:0];
   endfunction

   function automatic logic signed [Q_W-1:0] sat_add(input logic signed [Q_W-1:0] a,
                                                     input logic signed [Q_W-1:0] b);
      logic signed [Q_W:0] s;
      s = 33'(a) + 33'(b);
      return sat33(s);
   endfunction

   function automatic logic signed [Q_W-1:0] sat_sub(input logic signed [Q_W-1:0] a,
                                                     input logic signed [Q_W-1:0] b);
      logic signed [Q_W:0] s;
      s = 33'(a) - 33'(b);
      return sat33(s);
   endfunction

   // Full signed product of two Q8.24 words
   function automatic logic signed [63:0] mulq(input logic signed [Q_W-1:0] a,
                                               input logic signed [Q_W-1:0] b);
      logic signed [63:0] p;
      p = a * b;
      return p;
   endfunction

   // Round a product back to Q8.24, ties toward +infinity, then clamp
   function automatic logic signed [Q_W-1:0] fround(input logic signed [63:0] p);
      logic signed [63:0] q;
      logic signed [39:0] r;
      q = p + 64'sd8388608;
      r = q[63:24];
      if (r[39:31] != {9{r[39]}}) begin
         return r[39] ? Q_MIN : Q_MAX;
      end
      return r[31:0];
   endfunction

   // Widen an unsigned 25-bit register to a signed word
   function automatic logic signed [Q_W-1:0] ufix(input logic [CFG_W-1:0] x);
      return {{(Q_W-CFG_W){1'b0}}, x};
   endfunction

endpackage

>>> rtl/izhikevich_neuron_update.sv
// A result is presented from the output register after its request passes the stage registers.
// Throughput: one request per cycle while successive requests name different neurons and
// the output is not stalled; a request naming a neuron still in the 14-stage update pipeline
// waits for its write-back, since state is read from the one-read, one-write state RAM at
// accept and written at the end. Reset: registers take their defaults, then a clearing pass
// writes every RAM entry, one per cycle; requests stall until it ends, CSR writes are taken.
module izhikevich_neuron_update import izn_pkg::*; #(
   parameter int NEURONS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [Q_W-1:0]       csr_wdata
);

   localparam int DEPTH = (NEURONS < (1 << IDX_W)) ? NEURONS : (1 << IDX_W);
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

   cfg_type          cfg_ff;
   logic             clr_busy_ff;
   logic [AW-1:0]    clr_addr_ff;
   logic             accept;
   logic             req_live;
   logic             load_ready;
   logic             probe_hit;
   wb_type           wb;
   nrn_type          rd_data;
   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   nrn_type          ram_wr_data;

   function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] i);
      logic [31:0] w;
      w = 32'(i);
      return w[AW-1:0];
   endfunction

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DT_SCALE:      cfg_ff.dt_scale        <= csr_wdata[CFG_W-1:0];
            CSR_ADAPT_STEP:    cfg_ff.adapt_step      <= csr_wdata[CFG_W-1:0];
            CSR_ADAPT_GAIN:    cfg_ff.adapt_gain      <= csr_wdata[CFG_W-1:0];
            CSR_RESET_VOLTAGE: cfg_ff.reset_voltage   <= csr_wdata;
            CSR_SPIKE_ADAPT:   cfg_ff.spike_adapt_add <= csr_wdata;
            CSR_THRESHOLD:     cfg_ff.threshold       <= csr_wdata;
            CSR_AMPA_DECAY:    cfg_ff.ampa_decay      <= csr_wdata[CFG_W-1:0];
            CSR_GABA_DECAY:    cfg_ff.gaba_decay      <= csr_wdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // Sweep the state RAM after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == CLR_LAST) begin
            clr_busy_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   // Stall while clearing, while the pipeline is full and its output stalled, or on a neuron still in flight
   assign req_stall = clr_busy_ff || !load_ready || probe_hit;
   assign accept    = req_valid && !req_stall;
   assign req_live  = 32'(req_data.neuron_index) < 32'(NEURONS);

   // Select the RAM write source
   assign ram_wr_en   = clr_busy_ff || wb.en;
   assign ram_wr_addr = clr_busy_ff ? clr_addr_ff : to_addr(wb.idx);
   assign ram_wr_data = clr_busy_ff ? NRN_RESET : wb.data;

   izn_state_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .rd_en   (load_ready),
      .rd_addr (to_addr(req_data.neuron_index)),
      .rd_data (rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   izn_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_item    (req_data),
      .in_live    (req_live),
      .load_ready (load_ready),
      .rd_data    (rd_data),
      .cfg        (cfg_ff),
      .probe_idx  (req_data.neuron_index),
      .probe_hit  (probe_hit),
      .wb         (wb),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   a_clear_no_wb: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !wb.en)
      else $error("pipeline write-back during clearing pass");

   a_clear_span: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_busy_ff) |-> $past(clr_addr_ff) == CLR_LAST)
      else $error("clearing pass ended early");

endmodule

>>> rtl/izn_state_ram.sv
module izn_state_ram import izn_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output nrn_type       rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  nrn_type       wr_data
);

   nrn_type mem [DEPTH];
   nrn_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; hold data while the consumer stalls
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/izn_pipe.sv
module izn_pipe import izn_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  req_type          in_item,
   input  logic             in_live,
   output logic             load_ready,
   input  nrn_type          rd_data,
   input  cfg_type          cfg,
   input  logic [IDX_W-1:0] probe_idx,
   output logic             probe_hit,
   output wb_type           wb,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   localparam int NSTG = 14;

   // Working record carried down the pipeline; slots are reused between stages
   typedef struct packed {
      logic [IDX_W-1:0]      idx;
      logic                  live;
      logic                  spk;
      logic signed [Q_W-1:0] v;
      logic signed [Q_W-1:0] u;
      logic signed [Q_W-1:0] ge;
      logic signed [Q_W-1:0] gi;
      logic signed [Q_W-1:0] x;
      logic signed [Q_W-1:0] y;
      logic signed [Q_W-1:0] z;
      logic signed [63:0]    pa;
      logic signed [63:0]    pb;
      logic signed [63:0]    pc;
      logic signed [63:0]    pd;
   } work_type;

   work_type              stg_ff [1:NSTG];
   work_type              stg_in [1:NSTG];
   logic [NSTG:1]         vld_ff;
   logic [NSTG:1]         vld_src;
   logic [NSTG+1:1]       rdy;
   logic [NSTG:1]         hit_vec;
   logic signed [Q_W-1:0] fin_v;
   logic signed [Q_W-1:0] fin_u;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   // A stage may load when it is empty, some later stage has a bubble, or the output register can load
   assign rdy[NSTG+1] = !rsp_valid_ff || !rsp_stall;

   for (genvar k = 1; k <= NSTG; k++) begin : g_rdy
      assign rdy[k]     = rdy[NSTG+1] | ~(&vld_ff[NSTG:k]);
      assign hit_vec[k] = vld_ff[k] && (stg_ff[k].idx == probe_idx);
   end

   assign load_ready = rdy[1];
   assign probe_hit  = |hit_vec;
   assign vld_src    = {vld_ff[NSTG-1:1], in_valid};

   // Per-stage arithmetic
   always_comb begin
      work_type w;

      stg_in[1]      = '0;
      stg_in[1].idx  = in_item.neuron_index;
      stg_in[1].live = in_live;
      stg_in[1].x    = {1'b0, in_item.ampa_increment};
      stg_in[1].y    = {1'b0, in_item.gaba_increment};

      // add the increments to the stored conductances
      w = stg_ff[1];
      stg_in[2]    = w;
      stg_in[2].ge = sat_add(rd_data.excit, w.x);
      stg_in[2].gi = sat_add(rd_data.inhib, w.y);
      stg_in[2].v  = rd_data.membrane;
      stg_in[2].u  = rd_data.adaptation;

      // synaptic operands, square, linear term, decays
      w = stg_ff[2];
      stg_in[3]    = w;
      stg_in[3].x  = sat_sub('0, w.ge);
      stg_in[3].y  = sat_sub(w.v, K_EREV_INH);
      stg_in[3].pa = mulq(w.v, w.v);
      stg_in[3].pb = mulq(K_FIVE, w.v);
      stg_in[3].pc = mulq(w.ge, ufix(cfg.ampa_decay));
      stg_in[3].pd = mulq(w.gi, ufix(cfg.gaba_decay));

      // synaptic currents; round square, linear term, decayed conductances
      w = stg_ff[3];
      stg_in[4]    = w;
      stg_in[4].pa = mulq(w.x, w.v);
      stg_in[4].pb = mulq(w.y, w.gi);
      stg_in[4].x  = fround(w.pa);
      stg_in[4].y  = fround(w.pb);
      stg_in[4].ge = fround(w.pc);
      stg_in[4].gi = fround(w.pd);

      // quadratic term times forty; round the currents
      w = stg_ff[4];
      stg_in[5]    = w;
      stg_in[5].pa = mulq(w.x, K_FORTY);
      stg_in[5].x  = fround(w.pa);
      stg_in[5].z  = fround(w.pb);

      w = stg_ff[5];
      stg_in[6]   = w;
      stg_in[6].y = sat_add(fround(w.pa), w.y);

      w = stg_ff[6];
      stg_in[7]   = w;
      stg_in[7].y = sat_sub(sat_add(w.y, K_OFFSET), w.u);

      w = stg_ff[7];
      stg_in[8]   = w;
      stg_in[8].y = sat_sub(sat_add(w.y, w.x), w.z);

      // scale the derivative by the time step
      w = stg_ff[8];
      stg_in[9]    = w;
      stg_in[9].pa = mulq(ufix(cfg.dt_scale), w.y);

      w = stg_ff[9];
      stg_in[10]   = w;
      stg_in[10].v = sat_add(w.v, fround(w.pa));

      // adaptation drive from the new membrane; threshold test
      w = stg_ff[10];
      stg_in[11]     = w;
      stg_in[11].pa  = mulq(w.v, ufix(cfg.adapt_gain));
      stg_in[11].spk = $signed(w.v) > $signed(cfg.threshold);

      w = stg_ff[11];
      stg_in[12]   = w;
      stg_in[12].y = sat_sub(fround(w.pa), w.u);

      w = stg_ff[12];
      stg_in[13]    = w;
      stg_in[13].pa = mulq(ufix(cfg.adapt_step), w.y);

      w = stg_ff[13];
      stg_in[14]   = w;
      stg_in[14].u = sat_add(w.u, fround(w.pa));
   end

   // Advance stage payloads
   always_ff @(posedge clock) begin
      for (int k = 1; k <= NSTG; k++) begin
         if (rdy[k]) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   // Advance stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= NSTG; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_src[k];
            end
         end
      end
   end

   // Apply the spike reset
   always_comb begin
      if (stg_ff[NSTG].spk) begin
         fin_v = cfg.reset_voltage;
         fin_u = sat_add(stg_ff[NSTG].u, cfg.spike_adapt_add);
      end else begin
         fin_v = stg_ff[NSTG].v;
         fin_u = stg_ff[NSTG].u;
      end
   end

   // Write back as the transaction moves into the output register
   always_comb begin
      wb.en              = vld_ff[NSTG] && stg_ff[NSTG].live && rdy[NSTG+1];
      wb.idx             = stg_ff[NSTG].idx;
      wb.data.membrane   = fin_v;
      wb.data.adaptation = fin_u;
      wb.data.excit      = stg_ff[NSTG].ge;
      wb.data.inhib      = stg_ff[NSTG].gi;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rdy[NSTG+1]) begin
         rsp_valid_ff <= vld_ff[NSTG];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[NSTG+1]) begin
         rsp_data_ff.neuron_out <= stg_ff[NSTG].idx;
         rsp_data_ff.spiked     <= stg_ff[NSTG].live && stg_ff[NSTG].spk;
         rsp_data_ff.membrane   <= stg_ff[NSTG].live ? fin_v : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_wb_then_rsp: assert property (@(posedge clock) disable iff (reset)
      wb.en |=> rsp_valid_ff && (rsp_data_ff.neuron_out == $past(wb.idx)))
      else $error("write-back without matching result");

   a_last_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NSTG] && !rdy[NSTG] |=> vld_ff[NSTG] && $stable(stg_ff[NSTG].idx))
      else $error("last stage lost a stalled transaction");

endmodule
